FILE: src/rls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator package
// Field widths, status codes and the controller/datapath handshake types.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int ACTION_W   = 1;
  localparam int BUF_IDX_W  = 2;
  localparam int SLOT_IDX_W = 9;
  localparam int STATUS_W   = 2;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BUFFER  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

  typedef struct packed {
    logic                load;
    logic                acq_open;
    logic                acq_read;
    logic                acq_take;
    logic                scan_start;
    logic                scan_read;
    logic                rel_grow;
    logic                rel_append;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                push;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic req_invalid;
    logic table_empty;
    logic table_full;
    logic buffers_full;
    logic scan_more;
    logic hit;
    logic out_busy;
  } dp_sts_t;

endpackage : rls_pkg
`default_nettype wire

FILE: src/rls_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface rls_req_if
  import rls_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [BUF_IDX_W-1:0]  buffer_index;
  logic [SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, action, buffer_index, slot_index, input ready);
  modport sink   (input valid, action, buffer_index, slot_index, output ready);
endinterface : rls_req_if

interface rls_res_if
  import rls_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_IDX_W-1:0] granted_slot;
  logic [BUF_IDX_W-1:0]  granted_buffer;

  modport source (output valid, status, granted_slot, granted_buffer, input ready);
  modport sink   (input valid, status, granted_slot, granted_buffer, output ready);
endinterface : rls_res_if
`default_nettype wire

FILE: src/rls_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rls_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : rls_ram
`default_nettype wire

FILE: src/rls_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator controller
// Sequences acquire and release requests and drives the datapath commands.
// ----------------------------------------------------------------------------
module rls_ctrl
  import rls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output      logic    in_ready,
  input  wire dp_sts_t sts,
  output      dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_ACQ_TAKE = 3'd2;
  localparam logic [2:0] S_REL_SCAN = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       rd_pend_r, rd_pend_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    rd_pend_nxt = rd_pend_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_release) begin
          if (sts.table_empty) begin
            if (sts.buffers_full) begin
              cmd.res_set  = 1'b1;
              cmd.res_code = STATUS_NO_BUFFER;
            end else begin
              cmd.acq_open = 1'b1;
            end
            state_nxt = S_DONE;
          end else begin
            cmd.acq_read = 1'b1;
            state_nxt    = S_ACQ_TAKE;
          end
        end else if (sts.req_invalid) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STATUS_OK;
          state_nxt    = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          rd_pend_nxt    = 1'b0;
          state_nxt      = S_REL_SCAN;
        end
      end
      S_ACQ_TAKE: begin
        cmd.acq_take = 1'b1;
        state_nxt    = S_DONE;
      end
      S_REL_SCAN: begin
        // Check the entry read last cycle while the next read is in flight.
        if (rd_pend_r && sts.hit) begin
          cmd.rel_grow = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.scan_more) begin
          cmd.scan_read = 1'b1;
          rd_pend_nxt   = 1'b1;
        end else begin
          if (sts.table_full) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = STATUS_TABLE_FULL;
          end else begin
            cmd.rel_append = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

endmodule : rls_ctrl
`default_nettype wire

FILE: src/rls_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator datapath
// Region table, counters, adjacency compare and the output register.
// ----------------------------------------------------------------------------
module rls_dpath
  import rls_pkg::*;
#(
  parameter int SLOTS_PER_BUFFER = 512,
  parameter int MAX_BUFFERS      = 4,
  parameter int MAX_REGIONS      = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output      dp_sts_t               sts,
  input  wire logic [ACTION_W-1:0]   in_action,
  input  wire logic [BUF_IDX_W-1:0]  in_buffer_index,
  input  wire logic [SLOT_IDX_W-1:0] in_slot_index,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [STATUS_W-1:0]   out_status,
  output      logic [SLOT_IDX_W-1:0] out_granted_slot,
  output      logic [BUF_IDX_W-1:0]  out_granted_buffer
);

  localparam int OFF_W  = $clog2(SLOTS_PER_BUFFER);
  localparam int CNT_W  = $clog2(SLOTS_PER_BUFFER + 1);
  localparam int BUF_W  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int BOP_W  = $clog2(MAX_BUFFERS + 1);
  localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
  localparam int ADDR_W = $clog2(MAX_REGIONS);
  localparam int ENT_W  = BUF_W + CNT_W + OFF_W;
  localparam int CMP_W  = ((SLOT_IDX_W > CNT_W) ? SLOT_IDX_W : CNT_W) + 1;
  localparam int BX_W0  = (BUF_IDX_W > BUF_W) ? BUF_IDX_W : BUF_W;
  localparam int BX_W   = (BX_W0 > BOP_W) ? BX_W0 : BOP_W;

  // Request capture
  logic                  req_act_r;
  logic [BUF_IDX_W-1:0]  req_buf_r;
  logic [SLOT_IDX_W-1:0] req_slot_r;

  // Allocator state
  logic [RCNT_W-1:0] region_count_r, region_count_nxt;
  logic [BOP_W-1:0]  buffers_opened_r, buffers_opened_nxt;
  logic [RCNT_W-1:0] scan_addr_r;
  logic [ADDR_W-1:0] rd_addr_r;

  // Result and output registers
  logic [STATUS_W-1:0]   res_status_r;
  logic [SLOT_IDX_W-1:0] res_slot_r;
  logic [BUF_IDX_W-1:0]  res_buf_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic [BUF_IDX_W-1:0]  out_buf_r;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic [OFF_W-1:0] ent_off;
  logic [CNT_W-1:0] ent_cnt;
  logic [BUF_W-1:0] ent_buf;
  logic [OFF_W-1:0] wr_off;
  logic [CNT_W-1:0] wr_cnt;
  logic [BUF_W-1:0] wr_buf;

  logic [CMP_W-1:0] slot_x, off_x, cnt_x;
  logic [BX_W-1:0]  req_buf_x, ent_buf_x, bop_x;
  logic             adj_lo, adj_hi, same_buf;
  logic [CNT_W-1:0] cnt_dec;

  assign {ent_buf, ent_cnt, ent_off} = ram_rdata;

  assign slot_x    = CMP_W'(req_slot_r);
  assign off_x     = CMP_W'(ent_off);
  assign cnt_x     = CMP_W'(ent_cnt);
  assign req_buf_x = BX_W'(req_buf_r);
  assign ent_buf_x = BX_W'(ent_buf);
  assign bop_x     = BX_W'(buffers_opened_r);
  assign same_buf  = (ent_buf_x == req_buf_x);
  assign adj_lo    = (off_x == slot_x + CMP_W'(1));
  assign adj_hi    = (slot_x == off_x + cnt_x);
  assign cnt_dec   = ent_cnt - CNT_W'(1);

  always_comb begin
    sts.is_release   = (req_act_r == ACT_RELEASE);
    sts.req_invalid  = (req_buf_x >= bop_x) ||
                       (slot_x >= CMP_W'(SLOTS_PER_BUFFER));
    sts.table_empty  = (region_count_r == '0);
    sts.table_full   = (region_count_r == RCNT_W'(MAX_REGIONS));
    sts.buffers_full = (buffers_opened_r == BOP_W'(MAX_BUFFERS));
    sts.scan_more    = (scan_addr_r < region_count_r);
    sts.hit          = same_buf && (adj_lo || adj_hi);
    sts.out_busy     = out_valid_r && !out_ready;
  end

  // Table write and read selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_r;
    wr_off    = ent_off;
    wr_cnt    = ent_cnt;
    wr_buf    = ent_buf;
    ram_re    = cmd.acq_read || cmd.scan_read;
    ram_raddr = cmd.acq_read ? (region_count_r[ADDR_W-1:0] - ADDR_W'(1))
                             : scan_addr_r[ADDR_W-1:0];
    if (cmd.acq_open) begin
      // New buffer: slot 0 goes out, the rest stays as one region.
      ram_we    = 1'b1;
      ram_waddr = '0;
      wr_off    = OFF_W'(1);
      wr_cnt    = CNT_W'(SLOTS_PER_BUFFER - 1);
      wr_buf    = bop_x[BUF_W-1:0];
    end else if (cmd.acq_take) begin
      ram_we = 1'b1;
      wr_off = ent_off + OFF_W'(1);
      wr_cnt = cnt_dec;
    end else if (cmd.rel_grow) begin
      ram_we = 1'b1;
      wr_cnt = ent_cnt + CNT_W'(1);
      if (adj_lo) begin
        wr_off = ent_off - OFF_W'(1);
      end
    end else if (cmd.rel_append) begin
      ram_we    = 1'b1;
      ram_waddr = region_count_r[ADDR_W-1:0];
      wr_off    = OFF_W'(slot_x);
      wr_cnt    = CNT_W'(1);
      wr_buf    = req_buf_x[BUF_W-1:0];
    end
    ram_wdata = {wr_buf, wr_cnt, wr_off};
  end

  always_comb begin
    region_count_nxt   = region_count_r;
    buffers_opened_nxt = buffers_opened_r;
    if (cmd.acq_open) begin
      region_count_nxt   = RCNT_W'(1);
      buffers_opened_nxt = buffers_opened_r + BOP_W'(1);
    end else if (cmd.acq_take && (cnt_dec == '0)) begin
      // Drop the last region once it is empty.
      region_count_nxt = region_count_r - RCNT_W'(1);
    end else if (cmd.rel_append) begin
      region_count_nxt = region_count_r + RCNT_W'(1);
    end
  end

  rls_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act_r  <= in_action;
      req_buf_r  <= in_buffer_index;
      req_slot_r <= in_slot_index;
    end
    if (cmd.scan_start) begin
      scan_addr_r <= '0;
    end else if (cmd.scan_read) begin
      scan_addr_r <= scan_addr_r + RCNT_W'(1);
    end
    if (ram_re) begin
      rd_addr_r <= ram_raddr;
    end
    if (cmd.acq_open) begin
      res_status_r <= STATUS_OK;
      res_slot_r   <= '0;
      res_buf_r    <= bop_x[BUF_IDX_W-1:0];
    end else if (cmd.acq_take) begin
      res_status_r <= STATUS_OK;
      res_slot_r   <= off_x[SLOT_IDX_W-1:0];
      res_buf_r    <= ent_buf_x[BUF_IDX_W-1:0];
    end else if (cmd.rel_grow || cmd.rel_append) begin
      res_status_r <= STATUS_OK;
      res_slot_r   <= '0;
      res_buf_r    <= '0;
    end else if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_slot_r   <= '0;
      res_buf_r    <= '0;
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_buf_r    <= res_buf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r   <= '0;
      buffers_opened_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      region_count_r   <= region_count_nxt;
      buffers_opened_r <= buffers_opened_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_slot   = out_slot_r;
  assign out_granted_buffer = out_buf_r;

endmodule : rls_dpath
`default_nettype wire

FILE: src/region_list_slot_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator core
// Hands out and takes back slots, tracking free space as a region list.
// ----------------------------------------------------------------------------
// Acquire: the request is decoded, the last region is read and a slot taken;
//   no read when a buffer opens or none is left, nor for an ignored release.
// Release: regions are scanned up to the region count, one table entry per
//   cycle through the table's single read port, until an adjacent one is found.
// One request in work at a time; the next transfer is taken after the
// result moves to the output register, which waits while the last is not taken.
// Reset (synchronous, active low) empties the region list and closes all
// buffers; table contents are left as they are and need no clearing pass.
module region_list_slot_allocator_core
  import rls_pkg::*;
#(
  parameter int SLOTS_PER_BUFFER = 512,
  parameter int MAX_BUFFERS      = 4,
  parameter int MAX_REGIONS      = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rls_req_if.sink   in_req,
  rls_res_if.source out_res
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_req.ready = in_ready;

  rls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rls_dpath #(
    .SLOTS_PER_BUFFER (SLOTS_PER_BUFFER),
    .MAX_BUFFERS      (MAX_BUFFERS),
    .MAX_REGIONS      (MAX_REGIONS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_req.action),
    .in_buffer_index    (in_req.buffer_index),
    .in_slot_index      (in_req.slot_index),
    .out_valid          (out_res.valid),
    .out_ready          (out_res.ready),
    .out_status         (out_res.status),
    .out_granted_slot   (out_res.granted_slot),
    .out_granted_buffer (out_res.granted_buffer)
  );

endmodule : region_list_slot_allocator_core
`default_nettype wire

FILE: tb/region_list_slot_allocator_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region-list slot allocator core testbench
// Drives acquire and release requests through the request channel, tracks the
// free-region list in a scoreboard that predicts every result, and checks the
// result channel field by field under random sender and receiver stalls.
// ----------------------------------------------------------------------------
import rls_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0]   status;
  logic [SLOT_IDX_W-1:0] slot;
  logic [BUF_IDX_W-1:0]  buffer;
} grant_t;

class slot_ledger;
  localparam int unsigned SLOTS    = 512;
  localparam int unsigned MAX_BUFS = 4;
  localparam int unsigned MAX_REGS = 64;

  int unsigned reg_offset[MAX_REGS];
  int unsigned reg_count[MAX_REGS];
  int unsigned reg_buffer[MAX_REGS];
  int unsigned live_regions;
  int unsigned opened;

  grant_t      pending_grants[$];
  int unsigned errors;
  int unsigned grants, refusals, releases, full_drops, ignored;

  function new();
    live_regions = 0;
    opened       = 0;
    errors       = 0;
    grants       = 0;
    refusals     = 0;
    releases     = 0;
    full_drops   = 0;
    ignored      = 0;
  endfunction

  // Advance the region list by one accepted request and queue its result.
  function grant_t note_request(logic [ACTION_W-1:0] act, logic [BUF_IDX_W-1:0] bidx,
                                logic [SLOT_IDX_W-1:0] sidx);
    grant_t      g;
    int unsigned i, s;
    bit          placed;
    g.status = STATUS_OK;
    g.slot   = '0;
    g.buffer = '0;
    s        = sidx;
    placed   = 1'b0;
    if (act == ACT_ACQUIRE) begin
      if (live_regions == 0 && opened >= MAX_BUFS) begin
        g.status = STATUS_NO_BUFFER;
        refusals++;
      end else begin
        if (live_regions == 0) begin
          reg_offset[0] = 0;
          reg_count[0]  = SLOTS;
          reg_buffer[0] = opened;
          opened++;
          live_regions = 1;
        end
        i        = live_regions - 1;
        g.slot   = SLOT_IDX_W'(reg_offset[i]);
        g.buffer = BUF_IDX_W'(reg_buffer[i]);
        reg_offset[i]++;
        reg_count[i]--;
        if (reg_count[i] == 0) live_regions--;
        grants++;
      end
    end else if (bidx >= opened || s >= SLOTS) begin
      ignored++;
    end else begin
      releases++;
      // first region of the same buffer touching the slot on either side wins
      for (i = 0; i < live_regions && !placed; i++) begin
        if (reg_buffer[i] == bidx) begin
          if (reg_offset[i] == s + 1) begin
            reg_offset[i]--;
            reg_count[i]++;
            placed = 1'b1;
          end else if (s == reg_offset[i] + reg_count[i]) begin
            reg_count[i]++;
            placed = 1'b1;
          end
        end
      end
      if (!placed) begin
        if (live_regions >= MAX_REGS) begin
          g.status = STATUS_TABLE_FULL;
          full_drops++;
        end else begin
          reg_offset[live_regions] = s;
          reg_count[live_regions]  = 1;
          reg_buffer[live_regions] = bidx;
          live_regions++;
        end
      end
    end
    pending_grants = {pending_grants, g};
    return g;
  endfunction

  function void check_grant(logic [STATUS_W-1:0] st, logic [SLOT_IDX_W-1:0] sl,
                            logic [BUF_IDX_W-1:0] bf);
    grant_t want;
    if (pending_grants.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: status %0d slot %0d buffer %0d",
               $time, st, sl, bf);
      return;
    end
    want = pending_grants.pop_front();
    if (st !== want.status) begin
      errors++;
      $display("%0t: status expected %0d, actual %0d", $time, want.status, st);
    end
    if (sl !== want.slot) begin
      errors++;
      $display("%0t: granted_slot expected %0d, actual %0d", $time, want.slot, sl);
    end
    if (bf !== want.buffer) begin
      errors++;
      $display("%0t: granted_buffer expected %0d, actual %0d", $time, want.buffer, bf);
    end
  endfunction
endclass

module region_list_slot_allocator_core_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [BUF_IDX_W-1:0]  buffer;
    logic [SLOT_IDX_W-1:0] slot;
  } slot_ref_t;

  logic clk = 1'b0;
  logic rst_n;

  rls_req_if in_req ();
  rls_res_if out_res ();

  region_list_slot_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  slot_ledger  ledger = new();
  slot_ref_t   held_slots[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      ledger.check_grant(out_res.status, out_res.granted_slot, out_res.granted_buffer);
    end
    out_res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic issue_request(logic [ACTION_W-1:0] act, logic [BUF_IDX_W-1:0] bidx,
                               logic [SLOT_IDX_W-1:0] sidx);
    grant_t    g;
    slot_ref_t kept;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.action       <= act;
    in_req.buffer_index <= bidx;
    in_req.slot_index   <= sidx;
    do @(posedge clk); while (!in_req.ready);
    g = ledger.note_request(act, bidx, sidx);
    if (act == ACT_ACQUIRE && g.status == STATUS_OK) begin
      kept.buffer = g.buffer;
      kept.slot   = g.slot;
      held_slots  = {held_slots, kept};
    end
  endtask

  task automatic acquire_one();
    issue_request(ACT_ACQUIRE, BUF_IDX_W'($urandom), SLOT_IDX_W'($urandom));
  endtask

  task automatic run_directed();
    issue_request(ACT_RELEASE, 2'd3, 9'd511);   // no buffer open yet: dropped
    issue_request(ACT_RELEASE, 2'd0, 9'd0);
    acquire_one();                              // opens buffer 0
    acquire_one();
    acquire_one();
    issue_request(ACT_RELEASE, 2'd0, 9'd1);     // isolated: new one-slot region
    acquire_one();                              // empties that region
    issue_request(ACT_RELEASE, 2'd0, 9'd2);     // grows the big region downward
    issue_request(ACT_RELEASE, 2'd0, 9'd0);
    issue_request(ACT_RELEASE, 2'd0, 9'd1);     // adjoins both; first match grows
    issue_request(ACT_RELEASE, 2'd0, 9'd1);     // double free
    issue_request(ACT_RELEASE, 2'd0, 9'd511);   // top slot, double free
    issue_request(ACT_RELEASE, 2'd1, 9'd256);   // unopened buffer
    issue_request(ACT_RELEASE, 2'd2, 9'd170);
    issue_request(ACT_ACQUIRE, 2'd3, 9'd511);   // ignored fields at their extremes
    issue_request(ACT_ACQUIRE, 2'd0, 9'd0);
    acquire_one();
  endtask

  // Mix acquire bursts, releases of held slots, comb-pattern releases that
  // fill the table, and random noise releases.
  task automatic run_mix(int unsigned quota, int unsigned acq_pct);
    int unsigned      done_items, pick, len, idx;
    slot_ref_t        victim;
    logic [BUF_IDX_W-1:0]  nb;
    logic [SLOT_IDX_W-1:0] ns;
    done_items = 0;
    while (done_items < quota) begin
      pick = $urandom_range(99);
      if (pick < acq_pct) begin
        len = $urandom_range(40, 1);
        repeat (len) acquire_one();
        done_items += len;
      end else if (pick < 88) begin
        len = $urandom_range(20, 1);
        repeat (len) begin
          if (held_slots.size() != 0) begin
            idx    = $urandom_range(held_slots.size() - 1);
            victim = held_slots[idx];
            held_slots.delete(idx);
            issue_request(ACT_RELEASE, victim.buffer, victim.slot);
            done_items++;
          end
        end
      end else if (pick < 94) begin
        // release every other held slot: neighbors stay held, so no merging
        len = $urandom_range(80, 40);
        idx = 0;
        repeat (len) begin
          if (idx < held_slots.size()) begin
            victim = held_slots[idx];
            held_slots.delete(idx);
            issue_request(ACT_RELEASE, victim.buffer, victim.slot);
            done_items++;
            idx++;
          end
        end
      end else begin
        len = $urandom_range(3, 1);
        repeat (len) begin
          nb = BUF_IDX_W'($urandom);
          ns = SLOT_IDX_W'($urandom);
          if (nb < ledger.opened) done_items++;
          issue_request(ACT_RELEASE, nb, ns);
        end
      end
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("region_list_slot_allocator_core_tb: done, errors");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    in_req.valid         = 1'b0;
    in_req.action        = ACT_ACQUIRE;
    in_req.buffer_index  = '0;
    in_req.slot_index    = '0;
    out_res.ready        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    send_idle_pct = 30;
    recv_idle_pct = 46;
    run_mix(300, 60);

    send_idle_pct = 46;
    recv_idle_pct = 30;
    run_mix(300, 70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // exhaust every buffer, then keep asking
    while (ledger.refusals < 6) acquire_one();
    run_mix(100, 45);

    in_req.valid <= 1'b0;
    while (ledger.pending_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d grants, %0d out-of-buffer refusals, %0d releases",
             ledger.grants, ledger.refusals, ledger.releases);
    $display("  %0d table-full drops, %0d ignored releases, %0d buffers opened",
             ledger.full_drops, ledger.ignored, ledger.opened);
    if (ledger.errors == 0) begin
      $display("region_list_slot_allocator_core_tb: done, clean");
    end else begin
      $display("region_list_slot_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule : region_list_slot_allocator_core_tb
`default_nettype wire
